// ===== hw/rtl/sfd_pkg.sv =====
// Shared constants and types of the SLIP frame decoder.
`timescale 1ns / 1ps
package sfd_pkg;

  localparam int MAX_PACKET_DFLT = 2048;
  localparam int CNT_W           = 12;

  localparam logic [7:0] SLIP_END     = 8'o300;
  localparam logic [7:0] SLIP_ESC     = 8'o333;
  localparam logic [7:0] SLIP_ESC_END = 8'o334;
  localparam logic [7:0] SLIP_ESC_ESC = 8'o335;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_GOOD   = 2'd1,
    KIND_BADLEN = 2'd2,
    KIND_ABORT  = 2'd3
  } sfd_kind_t;

  typedef struct packed {
    sfd_kind_t        kind;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] position;
  } sfd_result_t;

endpackage

// ===== hw/rtl/sfd_if.sv =====
// Handshake channels of the SLIP frame decoder: received bytes and results.
`timescale 1ns / 1ps
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [11:0] position;

  modport source (output valid, output kind, output data_byte, output position, input ready);
  modport sink (input valid, input kind, input data_byte, input position, output ready);
endinterface

// ===== hw/rtl/sfd_in_reg.sv =====
// Input register holding one received byte until the parser takes it.
`timescale 1ns / 1ps
module sfd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || advance;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

endmodule

// ===== hw/rtl/sfd_parser.sv =====
// SLIP unstuffing state machine: parse mode, byte count and result decode.
`timescale 1ns / 1ps
module sfd_parser #(
  parameter int MAX_PACKET = sfd_pkg::MAX_PACKET_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output sfd_pkg::sfd_result_t res
);
  import sfd_pkg::*;

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_PACKET);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_PKT  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HUNT = 2'd3
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             acc;
  logic [7:0]       acc_byte;
  logic             abort;

  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    acc       = 1'b0;
    acc_byte  = rx_byte;
    abort     = 1'b0;
    res_valid = 1'b0;
    res       = '{kind: KIND_DATA, data_byte: 8'd0, position: cnt_r};
    unique case (mode_r)
      MODE_IDLE, MODE_PKT: begin
        if (rx_byte == SLIP_END) begin
          cnt_nxt  = '0;
          mode_nxt = MODE_IDLE;
          if (cnt_r != '0) begin
            res_valid = 1'b1;
            res.kind  = (cnt_r[1:0] == 2'b00) ? KIND_GOOD : KIND_BADLEN;
          end
        end else if (rx_byte == SLIP_ESC) begin
          mode_nxt = MODE_ESC;
        end else begin
          acc = 1'b1;
        end
      end
      MODE_ESC: begin
        if (rx_byte == SLIP_ESC_END) begin
          acc      = 1'b1;
          acc_byte = SLIP_END;
        end else if (rx_byte == SLIP_ESC_ESC) begin
          acc      = 1'b1;
          acc_byte = SLIP_ESC;
        end else begin
          abort = 1'b1;
        end
      end
      MODE_HUNT: begin
        if (rx_byte == SLIP_END) begin
          cnt_nxt  = '0;
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
    if (acc) begin
      if (cnt_r < MaxCnt) begin
        res_valid     = 1'b1;
        res.data_byte = acc_byte;
        cnt_nxt       = cnt_r + CNT_W'(1);
        mode_nxt      = MODE_PKT;
      end else begin
        abort = 1'b1;
      end
    end
    if (abort) begin
      res_valid = 1'b1;
      res.kind  = KIND_ABORT;
      mode_nxt  = MODE_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= '0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/sfd_out_reg.sv =====
// Result register facing the downstream channel.
`timescale 1ns / 1ps
module sfd_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sfd_pkg::sfd_result_t res,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sfd_pkg::sfd_result_t out_res
);
  import sfd_pkg::*;

  logic        valid_r;
  sfd_result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
    if (can_load && load) begin
      res_r <= res;
    end
  end

endmodule

// ===== hw/rtl/slip_frame_decoder.sv =====
// Top level of the SLIP frame decoder.
`timescale 1ns / 1ps
// Decodes a SLIP byte stream: each accepted byte is held in the input register,
// the parser updates its mode and byte count, and any result lands in the output
// register. Bytes are taken at one word per cycle while the result register
// can drain. A result is a data byte with its index, a done word carrying the
// packet length (good when a multiple of four), or an abort on overflow past
// MAX_PACKET or a bad escape, after which bytes are dropped until the next END.
// Empty packets and bytes that only change mode produce no result.
module slip_frame_decoder #(
  parameter int MAX_PACKET = sfd_pkg::MAX_PACKET_DFLT
) (
  input logic        clk,
  input logic        rst_n,
  sfd_in_if.sink     in_chan,
  sfd_out_if.source  out_chan
);
  import sfd_pkg::*;

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        advance;
  logic        can_load;
  logic        res_valid;
  sfd_result_t res;
  sfd_result_t out_res;

  assign advance = hold_valid && can_load;

  sfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_byte    (in_chan.rx_byte),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  sfd_parser #(
    .MAX_PACKET (MAX_PACKET)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .rx_byte   (hold_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.kind      = out_res.kind;
  assign out_chan.data_byte = out_res.data_byte;
  assign out_chan.position  = out_res.position;

endmodule

// ===== tb/tb_slip_frame_decoder.sv =====
// Self-checking testbench of the SLIP frame decoder: directed table, random frames, limit packet.
`timescale 1ns / 1ps
module tb_slip_frame_decoder;
  import sfd_pkg::*;

  localparam int MAX_PKT     = MAX_PACKET_DFLT;
  localparam int RUN_ITEMS   = 1250;
  localparam int TAIL_CYCLES = 20;

  typedef enum logic [1:0] {
    PM_IDLE = 2'd0,
    PM_PKT  = 2'd1,
    PM_ESC  = 2'd2,
    PM_HUNT = 2'd3
  } parse_mode_t;

  typedef enum int {
    CHK_MODEL,
    CHK_NONE,
    CHK_FIXED
  } row_check_t;

  typedef struct {
    logic [7:0]  rx;
    row_check_t  chk;
    sfd_kind_t   kind;
    logic [7:0]  data;
    logic [11:0] pos;
  } dir_row_t;

  dir_row_t dir_rows [0:24] = '{
    '{SLIP_END,     CHK_NONE,  KIND_DATA,   8'h00, 12'd0},
    '{8'h00,        CHK_FIXED, KIND_DATA,   8'h00, 12'd0},
    '{8'hFF,        CHK_FIXED, KIND_DATA,   8'hFF, 12'd1},
    '{SLIP_ESC,     CHK_NONE,  KIND_DATA,   8'h00, 12'd0},
    '{SLIP_ESC_END, CHK_MODEL, KIND_DATA,   8'h00, 12'd0},
    '{SLIP_ESC,     CHK_NONE,  KIND_DATA,   8'h00, 12'd0},
    '{SLIP_ESC_ESC, CHK_MODEL, KIND_DATA,   8'h00, 12'd0},
    '{SLIP_END,     CHK_FIXED, KIND_GOOD,   8'h00, 12'd4},
    '{SLIP_END,     CHK_NONE,  KIND_DATA,   8'h00, 12'd0},
    '{8'h55,        CHK_MODEL, KIND_DATA,   8'h00, 12'd0},
    '{SLIP_END,     CHK_FIXED, KIND_BADLEN, 8'h00, 12'd1},
    '{8'hAA,        CHK_MODEL, KIND_DATA,   8'h00, 12'd0},
    '{SLIP_ESC,     CHK_NONE,  KIND_DATA,   8'h00, 12'd0},
    '{8'h41,        CHK_FIXED, KIND_ABORT,  8'h00, 12'd1},
    '{8'h12,        CHK_NONE,  KIND_DATA,   8'h00, 12'd0},
    '{SLIP_END,     CHK_NONE,  KIND_DATA,   8'h00, 12'd0},
    '{SLIP_ESC,     CHK_NONE,  KIND_DATA,   8'h00, 12'd0},
    '{SLIP_END,     CHK_FIXED, KIND_ABORT,  8'h00, 12'd0},
    '{SLIP_END,     CHK_NONE,  KIND_DATA,   8'h00, 12'd0},
    '{SLIP_ESC,     CHK_NONE,  KIND_DATA,   8'h00, 12'd0},
    '{SLIP_ESC,     CHK_FIXED, KIND_ABORT,  8'h00, 12'd0},
    '{SLIP_END,     CHK_NONE,  KIND_DATA,   8'h00, 12'd0},
    '{SLIP_ESC_END, CHK_MODEL, KIND_DATA,   8'h00, 12'd0},
    '{SLIP_ESC_ESC, CHK_MODEL, KIND_DATA,   8'h00, 12'd0},
    '{SLIP_END,     CHK_FIXED, KIND_BADLEN, 8'h00, 12'd2}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  slip_frame_decoder #(.MAX_PACKET(MAX_PKT)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  parse_mode_t   dec_mode  = PM_IDLE;
  logic [11:0]   dec_count = '0;
  sfd_result_t   pending [$];
  int            mismatches = 0;
  int            fed_count  = 0;
  bit            calm_run   = 1'b0;
  logic [7:0]    phase_cnt  = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    phase_cnt <= phase_cnt + 1'b1;
    if (phase_cnt == 8'd0) begin
      calm_run <= ($urandom_range(0, 3) == 0);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit store_byte(input logic [7:0] v, output sfd_result_t r);
    r = '{KIND_DATA, 8'h00, 12'd0};
    r.position = dec_count;
    if (dec_count < MAX_PKT) begin
      r.data_byte = v;
      dec_count = dec_count + 1'b1;
      dec_mode = PM_PKT;
    end else begin
      r.kind = KIND_ABORT;
      dec_mode = PM_HUNT;
    end
    return 1'b1;
  endfunction

  function automatic bit unstuff(input logic [7:0] c, output sfd_result_t r);
    r = '{KIND_DATA, 8'h00, 12'd0};
    case (dec_mode)
      PM_IDLE, PM_PKT: begin
        if (c == SLIP_END) begin
          r.kind = (dec_count[1:0] == 2'd0) ? KIND_GOOD : KIND_BADLEN;
          r.position = dec_count;
          dec_count = '0;
          dec_mode = PM_IDLE;
          return r.position != 12'd0;
        end
        if (c == SLIP_ESC) begin
          dec_mode = PM_ESC;
          return 1'b0;
        end
        return store_byte(c, r);
      end
      PM_ESC: begin
        if (c == SLIP_ESC_END) return store_byte(SLIP_END, r);
        if (c == SLIP_ESC_ESC) return store_byte(SLIP_ESC, r);
        r.kind = KIND_ABORT;
        r.position = dec_count;
        dec_mode = PM_HUNT;
        return 1'b1;
      end
      default: begin
        if (c == SLIP_END) begin
          dec_count = '0;
          dec_mode = PM_IDLE;
        end
        return 1'b0;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return SLIP_END;
    if (r == 1) return SLIP_ESC;
    if (r == 2) return ($urandom_range(0, 1) == 0) ? SLIP_ESC_END : SLIP_ESC_ESC;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 7))
      0: return SLIP_END;
      1: return SLIP_ESC;
      2: return SLIP_ESC_END;
      3: return SLIP_ESC_ESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_bad_escape();
    logic [7:0] v;
    case ($urandom_range(0, 3))
      0: return SLIP_END;
      1: return SLIP_ESC;
      default: begin
        do v = 8'($urandom_range(0, 255));
        while (v == SLIP_ESC_END || v == SLIP_ESC_ESC);
        return v;
      end
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 8);
    if (r < 95) return $urandom_range(9, 64);
    return $urandom_range(65, 300);
  endfunction

  task automatic drive_word(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk);
    while (in_ch.ready !== 1'b1);
  endtask

  task automatic feed(input logic [7:0] b);
    sfd_result_t r;
    drive_word(b);
    if (unstuff(b, r)) pending.push_back(r);
    fed_count++;
  endtask

  task automatic feed_payload(input logic [7:0] v);
    if (v == SLIP_END) begin
      feed(SLIP_ESC);
      feed(SLIP_ESC_END);
    end else if (v == SLIP_ESC) begin
      feed(SLIP_ESC);
      feed(SLIP_ESC_ESC);
    end else begin
      feed(v);
    end
  endtask

  initial begin : drain
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_out
    sfd_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending.size() == 0) begin
        $error("unexpected word: kind %0d data %0h position %0d",
               out_ch.kind, out_ch.data_byte, out_ch.position);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
          mismatches++;
        end
        if (out_ch.data_byte !== want.data_byte) begin
          $error("data_byte: expected %0h, actual %0h", want.data_byte, out_ch.data_byte);
          mismatches++;
        end
        if (out_ch.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_ch.position);
          mismatches++;
        end
      end
    end
  end

  initial begin : stim
    sfd_result_t r;
    bit          got;
    int          sel;
    int          len;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      drive_word(dir_rows[i].rx);
      got = unstuff(dir_rows[i].rx, r);
      case (dir_rows[i].chk)
        CHK_MODEL: if (got) pending.push_back(r);
        CHK_FIXED: pending.push_back('{dir_rows[i].kind, dir_rows[i].data, dir_rows[i].pos});
        default: ;
      endcase
    end

    while (fed_count < RUN_ITEMS) begin
      sel = $urandom_range(0, 99);
      len = pick_len();
      if ($urandom_range(0, 3) == 0) feed(SLIP_END);
      if (sel < 75) begin
        repeat (len) feed_payload(pick_payload());
        feed(SLIP_END);
      end else if (sel < 88) begin
        repeat (len) feed_payload(pick_payload());
        feed(SLIP_ESC);
        feed(pick_bad_escape());
        repeat ($urandom_range(0, 4)) feed(pick_noise());
        if ($urandom_range(0, 3) != 0) feed(SLIP_END);
      end else begin
        repeat (len) feed(pick_noise());
      end
    end

    // fill to the limit with an escaped byte last, then overflow on a plain byte
    feed(SLIP_END);
    feed(SLIP_END);
    repeat (MAX_PKT - 1) feed(8'($urandom_range(0, 191)));
    feed(SLIP_ESC);
    feed(SLIP_ESC_ESC);
    feed(8'($urandom_range(0, 191)));
    feed(SLIP_END);

    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #30000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
